// ----- src/fts_pkg.sv -----
// Package for the flow table traffic statistics block.
// Holds sizes, protocol codes, transaction structs, controller states and
// the command/status bundles. No dependencies.
package fts_pkg;

    // Flow table depth and derived widths
    localparam int FLOW_ENTRIES = 1024;
    localparam int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);

    // Protocol numbers and flag bits
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam int         ACK_BIT   = 4;

    // Input transaction: one parsed header
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [15:0] ip_total_length;
        logic [3:0]  ip_header_words;
        logic [7:0]  tcp_flags;
    } t_fts_in;

    // Result transaction
    typedef struct packed {
        logic        new_flow;
        logic        table_full;
        logic [10:0] total_flows;
        logic [10:0] tcp_flows;
        logic [10:0] udp_flows;
        logic [31:0] total_packets;
        logic [31:0] tcp_packets;
        logic [31:0] udp_packets;
        logic [31:0] tcp_bytes;
        logic [31:0] udp_bytes;
        logic [31:0] ack_packets;
    } t_fts_out;

    // One stored flow: the 5-tuple
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
    } t_fts_key;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_UPDATE
    } t_fts_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic update;
    } t_fts_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic last;
    } t_fts_status;

    // Flow count to 11-bit result field
    function automatic logic [10:0] to_flow_field(input logic [CNT_W-1:0] c);
        logic [31:0] wide;
        wide = 32'(c);
        return wide[10:0];
    endfunction

endpackage

// ----- src/fts_ctrl.sv -----
// Controller for the flow table block: sequences load, table scan and update.
// Depends on fts_pkg.
module fts_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  fts_pkg::t_fts_status i_status,
    output logic                 busy,
    output fts_pkg::t_fts_cmd    o_cmd,
    output logic                 o_done
);
    import fts_pkg::*;

    t_fts_state r_state, n_state;
    logic       r_done;

    // State register and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_UPDATE);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = i_status.empty ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_SCAN:   o_cmd.rd_en  = 1'b1;
            ST_WAIT:   o_cmd        = '0;
            ST_UPDATE: o_cmd.update = 1'b1;
            default:   busy         = 1'b0;
        endcase
    end

    assign o_done = r_done;

endmodule

// ----- src/fts_datapath.sv -----
// Datapath for the flow table block: tuple memory, scan compare, counters.
// Depends on fts_pkg.
module fts_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fts_pkg::t_fts_in      i_item,
    input  fts_pkg::t_fts_cmd     i_cmd,
    output fts_pkg::t_fts_status  o_status,
    output fts_pkg::t_fts_out     o_result
);
    import fts_pkg::*;

    // Flow tuple memory, no reset
    t_fts_key    mem [FLOW_ENTRIES];

    t_fts_key    r_key;
    logic [15:0] r_payload;
    logic        r_ack;
    logic [IDX_W-1:0] r_idx;
    t_fts_key    r_rd_data;
    logic        r_rd_vld;
    logic        r_hit;
    logic        r_new;
    logic        r_full;

    logic [CNT_W-1:0] r_flow_cnt, r_tcp_flow_cnt, r_udp_flow_cnt;
    logic [31:0] r_pkt_cnt, r_tcp_pkt_cnt, r_udp_pkt_cnt;
    logic [31:0] r_tcp_byte_cnt, r_udp_byte_cnt, r_ack_cnt;

    logic [5:0]  hdr_bytes;
    logic [15:0] payload;
    logic        room;
    logic        is_tcp, is_udp, store;

    // Payload length, clamped at zero
    assign hdr_bytes = {i_item.ip_header_words, 2'b00};
    assign payload   = (i_item.ip_total_length > 16'(hdr_bytes))
                     ? i_item.ip_total_length - 16'(hdr_bytes) : 16'd0;

    assign room   = (r_flow_cnt < CNT_W'(FLOW_ENTRIES));
    assign is_tcp = (r_key.protocol == PROTO_TCP);
    assign is_udp = (r_key.protocol == PROTO_UDP);
    assign store  = !r_hit && room;

    // Latch the transaction and run the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key.src_ip   <= i_item.src_ip;
            r_key.dst_ip   <= i_item.dst_ip;
            r_key.sport    <= i_item.sport;
            r_key.dport    <= i_item.dport;
            r_key.protocol <= i_item.protocol;
            r_payload      <= payload;
            r_ack          <= i_item.tcp_flags[ACK_BIT];
            r_idx          <= '0;
        end else if (i_cmd.rd_en) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Memory read and write
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_idx];
        end
        if (i_cmd.update && store) begin
            mem[r_flow_cnt[IDX_W-1:0]] <= r_key;
        end
    end

    // Read valid and match flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (r_rd_vld && (r_rd_data == r_key)) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Counters and flags, updated once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_cnt     <= '0;
            r_tcp_flow_cnt <= '0;
            r_udp_flow_cnt <= '0;
            r_pkt_cnt      <= '0;
            r_tcp_pkt_cnt  <= '0;
            r_udp_pkt_cnt  <= '0;
            r_tcp_byte_cnt <= '0;
            r_udp_byte_cnt <= '0;
            r_ack_cnt      <= '0;
            r_new          <= 1'b0;
            r_full         <= 1'b0;
        end else if (i_cmd.update) begin
            r_new     <= !r_hit;
            r_full    <= !r_hit && !room;
            r_pkt_cnt <= r_pkt_cnt + 32'd1;
            if (store) begin
                r_flow_cnt <= r_flow_cnt + CNT_W'(1);
            end
            if (is_tcp) begin
                r_tcp_pkt_cnt  <= r_tcp_pkt_cnt + 32'd1;
                r_tcp_byte_cnt <= r_tcp_byte_cnt + 32'(r_payload);
                if (r_ack) begin
                    r_ack_cnt <= r_ack_cnt + 32'd1;
                end
                if (store) begin
                    r_tcp_flow_cnt <= r_tcp_flow_cnt + CNT_W'(1);
                end
            end
            if (is_udp) begin
                r_udp_pkt_cnt  <= r_udp_pkt_cnt + 32'd1;
                r_udp_byte_cnt <= r_udp_byte_cnt + 32'(r_payload);
                if (store) begin
                    r_udp_flow_cnt <= r_udp_flow_cnt + CNT_W'(1);
                end
            end
        end
    end

    // Status to controller
    assign o_status.empty = (r_flow_cnt == '0);
    assign o_status.last  = (CNT_W'(r_idx) == r_flow_cnt - CNT_W'(1));

    // Result fields
    assign o_result.new_flow      = r_new;
    assign o_result.table_full    = r_full;
    assign o_result.total_flows   = to_flow_field(r_flow_cnt);
    assign o_result.tcp_flows     = to_flow_field(r_tcp_flow_cnt);
    assign o_result.udp_flows     = to_flow_field(r_udp_flow_cnt);
    assign o_result.total_packets = r_pkt_cnt;
    assign o_result.tcp_packets   = r_tcp_pkt_cnt;
    assign o_result.udp_packets   = r_udp_pkt_cnt;
    assign o_result.tcp_bytes     = r_tcp_byte_cnt;
    assign o_result.udp_bytes     = r_udp_byte_cnt;
    assign o_result.ack_packets   = r_ack_cnt;

endmodule

// ----- src/flow_table_traffic_statistics_core.sv -----
// Flow table traffic statistics core: controller plus datapath.
// Per transaction: load on accepted start, a linear scan of the stored flows, up to FLOW_ENTRIES,
// reading one table entry per cycle from the tuple memory (ST_SCAN), then ST_WAIT (both skipped
// if the table is empty), then ST_UPDATE and a registered o_done. New starts are taken only when
// idle; start is taken in the cycle o_done is shown. The receiver cannot stall.
// Reset (synchronous, active low) clears all counters and flags; table contents are not cleared.
module flow_table_traffic_statistics_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  fts_pkg::t_fts_in  i_item,
    output logic              busy,
    output logic              o_done,
    output fts_pkg::t_fts_out o_result
);
    import fts_pkg::*;

    t_fts_cmd    cmd;
    t_fts_status status;

    // Sequencer
    fts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .busy     (busy),
        .o_cmd    (cmd),
        .o_done   (o_done)
    );

    // Table and counters
    fts_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result)
    );

endmodule

// ----- src/fts_checker.sv -----
// Port-level checks for the flow table core, bound to the top level.
// Depends on fts_pkg.
module fts_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              o_done,
    input  fts_pkg::t_fts_out o_result
);
    import fts_pkg::*;

    // An accepted transaction makes the core busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepted transaction");

    // A result comes only as the core finishes a transaction
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $fell(busy))
        else $error("result strobe without finished transaction");

    // Strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // Full table is only reported for a new flow
    a_full_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.table_full) |-> o_result.new_flow)
        else $error("table_full without new_flow");

endmodule

bind flow_table_traffic_statistics_core fts_checker u_fts_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ----- verif/flow_table_traffic_statistics_core_tb.sv -----
// Testbench for flow_table_traffic_statistics_core: directed and random traffic,
// checked against an in-bench flow table and counter predictor.
// Depends on fts_pkg and the core RTL only.
module flow_table_traffic_statistics_core_tb;
    import fts_pkg::*;

    localparam int         HDR_WORD_BYTES = 4;
    localparam logic [7:0] ACK_FLAG       = 8'(1 << ACK_BIT);
    localparam logic [7:0] PROTO_HOPOPT   = 8'd0;
    localparam logic [7:0] PROTO_ICMP     = 8'd1;
    localparam logic [7:0] PROTO_RESERVED = 8'd255;
    localparam int         RANDOM_ITEMS   = 564;
    localparam int         STALL_LIMIT    = 4 * (FLOW_ENTRIES + 16);
    localparam int         DRAIN_CYCLES   = 32;
    localparam int         MAX_REPORTS    = 200;

    typedef bit [$bits(t_fts_key)-1:0] t_key_bits;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_fts_in  i_item;
    logic     busy;
    logic     o_done;
    t_fts_out o_result;

    // Predictor state: stored tuples and running counters
    bit          flow_index[t_key_bits];
    t_fts_key    flow_list[$];
    int unsigned tcp_flows_stored;
    int unsigned udp_flows_stored;
    logic [31:0] pkts_all;
    logic [31:0] pkts_tcp;
    logic [31:0] pkts_udp;
    logic [31:0] bytes_tcp;
    logic [31:0] bytes_udp;
    logic [31:0] pkts_ack;

    t_fts_out expected_stats[$];
    int       mismatch_count;
    int       stall_cycles;
    bit       gaps_on;

    flow_table_traffic_statistics_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_fts_key header_key(input t_fts_in hdr);
        t_fts_key k;
        k.src_ip   = hdr.src_ip;
        k.dst_ip   = hdr.dst_ip;
        k.sport    = hdr.sport;
        k.dport    = hdr.dport;
        k.protocol = hdr.protocol;
        return k;
    endfunction

    function automatic bit is_stored(input t_fts_key k);
        return flow_index.exists(t_key_bits'(k));
    endfunction

    // Lookup, insert and counter update for one header; returns the stats after it
    function automatic t_fts_out predict_flow_stats(input t_fts_in hdr);
        t_fts_key    k;
        int unsigned hdr_bytes;
        int unsigned payload;
        bit          stored;
        t_fts_out    res;
        k         = header_key(hdr);
        stored    = 1'b0;
        res       = '0;
        hdr_bytes = int'(hdr.ip_header_words) * HDR_WORD_BYTES;
        payload   = (int'(hdr.ip_total_length) > hdr_bytes) ?
                    int'(hdr.ip_total_length) - hdr_bytes : 0;
        res.new_flow = !is_stored(k);
        if (res.new_flow) begin
            if (flow_list.size() < FLOW_ENTRIES) begin
                flow_index[t_key_bits'(k)] = 1'b1;
                flow_list.push_back(k);
                stored = 1'b1;
            end else begin
                res.table_full = 1'b1;
            end
        end
        if (hdr.protocol == PROTO_TCP) begin
            if (hdr.tcp_flags[ACK_BIT])
                pkts_ack = pkts_ack + 1;
            bytes_tcp = bytes_tcp + payload;
            pkts_tcp  = pkts_tcp + 1;
            if (stored)
                tcp_flows_stored++;
        end else if (hdr.protocol == PROTO_UDP) begin
            bytes_udp = bytes_udp + payload;
            pkts_udp  = pkts_udp + 1;
            if (stored)
                udp_flows_stored++;
        end
        pkts_all = pkts_all + 1;
        res.total_flows   = 11'(flow_list.size());
        res.tcp_flows     = 11'(tcp_flows_stored);
        res.udp_flows     = 11'(udp_flows_stored);
        res.total_packets = pkts_all;
        res.tcp_packets   = pkts_tcp;
        res.udp_packets   = pkts_udp;
        res.tcp_bytes     = bytes_tcp;
        res.udp_bytes     = bytes_udp;
        res.ack_packets   = pkts_ack;
        return res;
    endfunction

    function automatic t_fts_in make_header(input logic [31:0] sip, input logic [31:0] dip,
                                            input logic [15:0] sport, input logic [15:0] dport,
                                            input logic [7:0] proto, input logic [15:0] len,
                                            input logic [3:0] hwords, input logic [7:0] flags);
        t_fts_in h;
        h.src_ip          = sip;
        h.dst_ip          = dip;
        h.sport           = sport;
        h.dport           = dport;
        h.protocol        = proto;
        h.ip_total_length = len;
        h.ip_header_words = hwords;
        h.tcp_flags       = flags;
        return h;
    endfunction

    // Mostly TCP and UDP, some other protocol numbers
    function automatic t_fts_key rand_flow_key();
        t_fts_key k;
        int       sel;
        k.src_ip   = $urandom();
        k.dst_ip   = $urandom();
        k.sport    = 16'($urandom_range(0, 65535));
        k.dport    = 16'($urandom_range(0, 65535));
        sel = $urandom_range(0, 19);
        if (sel < 9)
            k.protocol = PROTO_TCP;
        else if (sel < 17)
            k.protocol = PROTO_UDP;
        else
            k.protocol = 8'($urandom_range(0, 255));
        return k;
    endfunction

    // Flip one bit of one tuple field
    function automatic t_fts_key perturb_key(input t_fts_key k);
        case ($urandom_range(0, 4))
            0: k.src_ip   = k.src_ip ^ (32'd1 << $urandom_range(0, 31));
            1: k.dst_ip   = k.dst_ip ^ (32'd1 << $urandom_range(0, 31));
            2: k.sport    = k.sport ^ (16'd1 << $urandom_range(0, 15));
            3: k.dport    = k.dport ^ (16'd1 << $urandom_range(0, 15));
            default: k.protocol = k.protocol ^ (8'd1 << $urandom_range(0, 7));
        endcase
        return k;
    endfunction

    // Tuple plus random length, header size and flags
    function automatic t_fts_in rand_header(input t_fts_key k);
        logic [15:0] len;
        len = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(20, 1500));
        return make_header(k.src_ip, k.dst_ip, k.sport, k.dport, k.protocol, len,
                           4'($urandom_range(0, 15)), 8'($urandom()));
    endfunction

    // Send one header; start stays high after acceptance until the next gap
    task automatic send_header(input t_fts_in hdr);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= hdr;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        expected_stats.push_back(predict_flow_stats(hdr));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (mismatch_count < MAX_REPORTS)
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker: one transaction per o_done strobe
    always @(posedge i_clk) begin
        t_fts_out want;
        if (i_rst_n && o_done) begin
            if (expected_stats.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $error("result with no pending transaction: 0x%0h", o_result);
                mismatch_count++;
            end else begin
                want = expected_stats.pop_front();
                check_field("new_flow", 32'(want.new_flow), 32'(o_result.new_flow));
                check_field("table_full", 32'(want.table_full), 32'(o_result.table_full));
                check_field("total_flows", 32'(want.total_flows), 32'(o_result.total_flows));
                check_field("tcp_flows", 32'(want.tcp_flows), 32'(o_result.tcp_flows));
                check_field("udp_flows", 32'(want.udp_flows), 32'(o_result.udp_flows));
                check_field("total_packets", want.total_packets, o_result.total_packets);
                check_field("tcp_packets", want.tcp_packets, o_result.tcp_packets);
                check_field("udp_packets", want.udp_packets, o_result.udp_packets);
                check_field("tcp_bytes", want.tcp_bytes, o_result.tcp_bytes);
                check_field("udp_bytes", want.udp_bytes, o_result.udp_bytes);
                check_field("ack_packets", want.ack_packets, o_result.ack_packets);
            end
        end
    end

    // Watchdog: cycles with no accepted transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("FAIL flow_table_traffic_statistics_core");
        $finish;
    end

    // Field extremes, every protocol class, ACK handling and payload corner cases
    task automatic test_directed_cases();
        send_header(make_header('0, '0, '0, '0, PROTO_TCP, 16'd0, 4'd0, ACK_FLAG));
        send_header(make_header('0, '0, '0, '0, PROTO_TCP, 16'd40, 4'd5, 8'h00));
        send_header(make_header('1, '1, '1, '1, PROTO_UDP, 16'hFFFF, 4'd0, 8'hFF));
        // negative payload clamps to zero
        send_header(make_header('1, '1, '1, '1, PROTO_UDP, 16'd10, 4'd15, 8'h00));
        // payload exactly zero, all flags set
        send_header(make_header(32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PROTO_TCP,
                                16'd60, 4'd15, 8'hFF));
        send_header(make_header(32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PROTO_TCP,
                                16'hFFFF, 4'd15, ~ACK_FLAG));
        // reversed direction is its own flow
        send_header(make_header(32'h0A000002, 32'h0A000001, 16'd80, 16'd1234, PROTO_TCP,
                                16'd52, 4'd5, ACK_FLAG));
        // same addresses and ports, other protocols
        send_header(make_header(32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PROTO_UDP,
                                16'd100, 4'd5, ACK_FLAG));
        send_header(make_header(32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PROTO_ICMP,
                                16'd84, 4'd5, ACK_FLAG));
        send_header(make_header('0, '0, '0, '0, PROTO_HOPOPT, 16'd40, 4'd5, 8'hFF));
        send_header(make_header('1, '1, '1, '1, PROTO_RESERVED, 16'hFFFF, 4'd15, 8'hFF));
        send_header(make_header('1, '1, '1, '1, PROTO_RESERVED, 16'd0, 4'd0, 8'h00));
        // one port bit away from a stored flow
        send_header(make_header(32'h0A000001, 32'h0A000002, 16'd1234, 16'd81, PROTO_TCP,
                                16'd1500, 4'd5, ACK_FLAG));
        // ACK on UDP is ignored
        send_header(make_header(32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PROTO_UDP,
                                16'd28, 4'd5, ACK_FLAG));
        send_header(make_header(32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 16'h5555, PROTO_TCP,
                                16'h5555, 4'hA, 8'hAA));
        send_header(make_header(32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA, PROTO_TCP,
                                16'hAAAA, 4'h5, 8'h55));
    endtask

    // Mix of new flows, revisits of stored flows and near misses
    task automatic test_random_traffic();
        t_fts_key k;
        int       sel;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gaps_on = (n < 420) && ((n / 50) % 3 != 2);
            sel = $urandom_range(0, 99);
            if (flow_list.size() == 0 || sel < 35)
                k = rand_flow_key();
            else if (sel < 85)
                k = flow_list[$urandom_range(0, flow_list.size() - 1)];
            else
                k = perturb_key(flow_list[$urandom_range(0, flow_list.size() - 1)]);
            send_header(rand_header(k));
        end
    endtask

    // Test sequence
    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_item           = '0;
        gaps_on          = 1'b1;
        tcp_flows_stored = 0;
        udp_flows_stored = 0;
        pkts_all         = '0;
        pkts_tcp         = '0;
        pkts_udp         = '0;
        bytes_tcp        = '0;
        bytes_udp        = '0;
        pkts_ack         = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic();

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("PASS flow_table_traffic_statistics_core");
        else
            $display("FAIL flow_table_traffic_statistics_core");
        $finish;
    end

endmodule
